@@ design/mmhs_pkg.sv @@
`default_nettype none
package mmhs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int RW        = PW + DW;
    localparam int SW        = PW + 2;
    localparam int IN_BITS   = 10 * DW + DW - 1;
    localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TW    = 3 * DW;

    localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] nr;
        logic signed [DW-1:0] ni;
        logic signed [DW-1:0] mzr;
        logic signed [DW-1:0] mzi;
        logic signed [DW-1:0] er;
        logic signed [DW-1:0] ei;
        logic signed [DW-1:0] ezr;
        logic signed [DW-1:0] ezi;
        logic                 ovf;
    } s1_t;

    typedef struct packed {
        logic        [PW-1:0] n;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
        logic                 ovf;
    } s2_t;

    typedef struct packed {
        logic [RW-1:0] r;
        logic [PW-1:0] n;
        logic [DW-1:0] q;
        logic          neg;
        logic          sat;
        logic          zero;
        logic          ovf;
    } dv_t;

    // {ovf, value}
    function automatic logic [DW:0] sat32(input logic signed [SW-1:0] v);
        logic [DW:0] res;
        if (v > SW'(MAX_V))
            res = {1'b1, MAX_V};
        else if (v < SW'(MIN_V))
            res = {1'b1, MIN_V};
        else
            res = {1'b0, v[DW-1:0]};
        return res;
    endfunction

    function automatic logic signed [SW-1:0] shf(input logic signed [PW-1:0] p);
        return SW'(p >>> FRAC_BITS);
    endfunction

endpackage
`default_nettype wire

@@ design/mmhs_front.sv @@
`default_nettype none
module mmhs_front
    import mmhs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [DW-1:0] a_re,
    input  wire logic signed [DW-1:0] a_im,
    input  wire logic signed [DW-1:0] b_re,
    input  wire logic signed [DW-1:0] b_im,
    input  wire logic signed [DW-1:0] c_re,
    input  wire logic signed [DW-1:0] c_im,
    input  wire logic signed [DW-1:0] d_re,
    input  wire logic signed [DW-1:0] d_im,
    input  wire logic signed [DW-1:0] point_x,
    input  wire logic signed [DW-1:0] point_y,
    input  wire logic        [DW-2:0] point_z,
    output logic                      out_valid,
    output s1_t                       out_data
);

    logic signed [PW-1:0] arx_reg, aiy_reg, ary_reg, aix_reg, arz_reg, aiz_reg;
    logic signed [PW-1:0] crx_reg, ciy_reg, cry_reg, cix_reg, crz_reg, ciz_reg;
    logic signed [DW-1:0] br_reg, bi_reg, dr_reg, di_reg;
    logic                 va_reg, vb_reg;
    s1_t                  s1_reg, s1_next;
    logic signed [DW-1:0] zs;
    logic [DW:0]          t0, t1, t2, t3, t4, t5, t6, t7;

    assign zs = {1'b0, point_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arx_reg <= a_re * point_x;
            aiy_reg <= a_im * point_y;
            ary_reg <= a_re * point_y;
            aix_reg <= a_im * point_x;
            arz_reg <= a_re * zs;
            aiz_reg <= a_im * zs;
            crx_reg <= c_re * point_x;
            ciy_reg <= c_im * point_y;
            cry_reg <= c_re * point_y;
            cix_reg <= c_im * point_x;
            crz_reg <= c_re * zs;
            ciz_reg <= c_im * zs;
            br_reg  <= b_re;
            bi_reg  <= b_im;
            dr_reg  <= d_re;
            di_reg  <= d_im;
            s1_reg  <= s1_next;
        end
    end

    always_comb
    begin
        t0 = sat32(shf(arx_reg) - shf(aiy_reg) + SW'(br_reg));
        t1 = sat32(shf(ary_reg) + shf(aix_reg) + SW'(bi_reg));
        t2 = sat32(shf(arz_reg));
        t3 = sat32(shf(aiz_reg));
        t4 = sat32(shf(crx_reg) - shf(ciy_reg) + SW'(dr_reg));
        t5 = sat32(shf(cry_reg) + shf(cix_reg) + SW'(di_reg));
        t6 = sat32(shf(crz_reg));
        t7 = sat32(shf(ciz_reg));
        s1_next.nr  = t0[DW-1:0];
        s1_next.ni  = t1[DW-1:0];
        s1_next.mzr = t2[DW-1:0];
        s1_next.mzi = t3[DW-1:0];
        s1_next.er  = t4[DW-1:0];
        s1_next.ei  = t5[DW-1:0];
        s1_next.ezr = t6[DW-1:0];
        s1_next.ezi = t7[DW-1:0];
        s1_next.ovf = t0[DW] | t1[DW] | t2[DW] | t3[DW] | t4[DW] | t5[DW] | t6[DW] | t7[DW];
    end

    assign out_valid = vb_reg;
    assign out_data  = s1_reg;

endmodule
`default_nettype wire

@@ design/mmhs_mid.sv @@
`default_nettype none
module mmhs_mid
    import mmhs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire s1_t  in_data,
    output logic      out_valid,
    output s2_t       out_data
);

    logic signed [PW-1:0] ee_reg, ii_reg, zr_reg, zi_reg;
    logic signed [PW-1:0] x0_reg, x1_reg, x2_reg, x3_reg;
    logic signed [PW-1:0] y0_reg, y1_reg, y2_reg, y3_reg;
    logic signed [PW-1:0] z0_reg, z1_reg, z2_reg, z3_reg;
    logic                 ovf_reg;
    logic                 va_reg, vb_reg;
    s2_t                  s2_reg, s2_next;
    logic signed [SW-1:0] nsum, xs, ys, zsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ee_reg  <= in_data.er * in_data.er;
            ii_reg  <= in_data.ei * in_data.ei;
            zr_reg  <= in_data.ezr * in_data.ezr;
            zi_reg  <= in_data.ezi * in_data.ezi;
            x0_reg  <= in_data.nr * in_data.er;
            x1_reg  <= in_data.ni * in_data.ei;
            x2_reg  <= in_data.mzr * in_data.ezr;
            x3_reg  <= in_data.mzi * in_data.ezi;
            y0_reg  <= in_data.ni * in_data.er;
            y1_reg  <= in_data.nr * in_data.ei;
            y2_reg  <= in_data.mzi * in_data.ezr;
            y3_reg  <= in_data.mzr * in_data.ezi;
            z0_reg  <= in_data.mzr * in_data.er;
            z1_reg  <= in_data.mzi * in_data.ei;
            z2_reg  <= in_data.nr * in_data.ezr;
            z3_reg  <= in_data.ni * in_data.ezi;
            ovf_reg <= in_data.ovf;
            s2_reg  <= s2_next;
        end
    end

    always_comb
    begin
        nsum = shf(ee_reg) + shf(ii_reg) + shf(zr_reg) + shf(zi_reg);
        xs   = shf(x0_reg) + shf(x1_reg) + shf(x2_reg) + shf(x3_reg);
        ys   = shf(y0_reg) - shf(y1_reg) + shf(y2_reg) - shf(y3_reg);
        zsum = shf(z0_reg) - shf(z1_reg) - shf(z2_reg) + shf(z3_reg);
        s2_next.n   = nsum[PW-1:0];
        s2_next.px  = xs[PW-1:0];
        s2_next.py  = ys[PW-1:0];
        s2_next.pz  = zsum[PW-1:0];
        s2_next.ovf = ovf_reg;
    end

    assign out_valid = vb_reg;
    assign out_data  = s2_reg;

endmodule
`default_nettype wire

@@ design/mmhs_div.sv @@
`default_nettype none
module mmhs_div
    import mmhs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [PW-1:0] num,
    input  wire logic        [PW-1:0] den,
    input  wire logic                 ovf_in,
    output logic                      out_valid,
    output logic signed [DW-1:0]      quo,
    output logic                      ovf
);

    dv_t                  st_reg [0:DW];
    logic                 v_reg  [0:DW];
    dv_t                  pre;
    logic [PW-1:0]        mag;
    logic [RW-1:0]        dvd;
    logic                 vo_reg;
    logic signed [DW-1:0] q_reg, q_next;
    logic                 o_reg, o_next;

    always_comb
    begin
        mag      = num[PW-1] ? PW'(-num) : PW'(num);
        dvd      = RW'(mag) << FRAC_BITS;
        pre.r    = dvd;
        pre.n    = den;
        pre.q    = '0;
        pre.neg  = num[PW-1];
        pre.sat  = dvd >= (RW'(den) << DW);
        pre.zero = (den == '0) && (num == '0);
        pre.ovf  = ovf_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DW; k++)
                v_reg[k] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DW; k++)
                v_reg[k] <= v_reg[k-1];
            vo_reg <= v_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg[0] <= pre;
    end

    for (genvar k = 1; k <= DW; k++)
    begin : g_step
        dv_t           s_next;
        logic [RW-1:0] sub;
        always_comb
        begin
            s_next = st_reg[k-1];
            sub    = RW'(st_reg[k-1].n) << (DW - k);
            if (!st_reg[k-1].sat && st_reg[k-1].r >= sub)
            begin
                s_next.r          = st_reg[k-1].r - sub;
                s_next.q[DW - k] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= s_next;
        end
    end

    always_comb
    begin
        o_next = st_reg[DW].ovf;
        if (st_reg[DW].zero)
        begin
            q_next = '0;
            o_next = 1'b1;
        end
        else if (st_reg[DW].sat)
        begin
            q_next = st_reg[DW].neg ? MIN_V : MAX_V;
            o_next = 1'b1;
        end
        else if (!st_reg[DW].neg)
        begin
            if (st_reg[DW].q > MAX_V)
            begin
                q_next = MAX_V;
                o_next = 1'b1;
            end
            else
                q_next = st_reg[DW].q;
        end
        else
        begin
            if (st_reg[DW].q > MIN_V)
            begin
                q_next = MIN_V;
                o_next = 1'b1;
            end
            else
                q_next = -st_reg[DW].q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
            o_reg <= o_next;
        end
    end

    assign out_valid = vo_reg;
    assign quo       = q_reg;
    assign ovf       = o_reg;

endmodule
`default_nettype wire

@@ design/mobius_map_half_space_unit.sv @@
// Pipeline: 2 product/sum stages, 2 norm/numerator stages and 34 divider stages, in that order;
// each divider step stage yields one quotient bit.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: rst_n asynchronous, active low; clears all valid bits, data is not reset.
`default_nettype none
module mobius_map_half_space_unit
    import mmhs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im, point_x, point_y, point_z, pad
    input  wire logic [IN_TW-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // out_x, out_y, out_z
    output logic [OUT_TW-1:0]      m_tdata,
    // overflow
    output logic                   m_tuser
);

    logic en;
    logic f_valid, m_valid, vx, vy, vz;
    s1_t  s1;
    s2_t  s2;
    logic signed [DW-1:0] qx, qy, qz;
    logic ox, oy, oz;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    mmhs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .a_re     (s_tdata[0*DW +: DW]),
        .a_im     (s_tdata[1*DW +: DW]),
        .b_re     (s_tdata[2*DW +: DW]),
        .b_im     (s_tdata[3*DW +: DW]),
        .c_re     (s_tdata[4*DW +: DW]),
        .c_im     (s_tdata[5*DW +: DW]),
        .d_re     (s_tdata[6*DW +: DW]),
        .d_im     (s_tdata[7*DW +: DW]),
        .point_x  (s_tdata[8*DW +: DW]),
        .point_y  (s_tdata[9*DW +: DW]),
        .point_z  (s_tdata[10*DW +: DW-1]),
        .out_valid(f_valid),
        .out_data (s1)
    );

    mmhs_mid u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_data  (s1),
        .out_valid(m_valid),
        .out_data (s2)
    );

    mmhs_div u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid),
        .num(s2.px), .den(s2.n), .ovf_in(s2.ovf),
        .out_valid(vx), .quo(qx), .ovf(ox)
    );

    mmhs_div u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid),
        .num(s2.py), .den(s2.n), .ovf_in(1'b0),
        .out_valid(vy), .quo(qy), .ovf(oy)
    );

    mmhs_div u_div_z (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_valid),
        .num(s2.pz), .den(s2.n), .ovf_in(1'b0),
        .out_valid(vz), .quo(qz), .ovf(oz)
    );

    assign m_tvalid = vx & vy & vz;
    assign m_tdata  = {qz, qy, qx};
    assign m_tuser  = ox | oy | oz;

endmodule
`default_nettype wire

@@ design/mmhs_checker.sv @@
`default_nettype none
module mmhs_checker
    import mmhs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_TW-1:0] m_tdata,
    input wire logic              m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> s_tready)
        else $error("input blocked while result drains");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipe holds");

endmodule

bind mobius_map_half_space_unit mmhs_checker u_mmhs_checker (
    .clk(clk), .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
